// ----- rtl/utf16le_to_utf8_replacing_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF16LE_TO_UTF8_REPLACING_ASSERT_SVH
`define UTF16LE_TO_UTF8_REPLACING_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define U16U8_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent in the next cycle
`define U16U8_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// check that also runs while reset is asserted
`define U16U8_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants and the encoder result record.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // most bytes one code unit can produce (replacement plus three-byte unit)
  localparam int unsigned MAX_BYTES = 6;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned REPL_LEN  = 3;

  // U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // surrogate tags in the upper six bits of a code unit
  localparam logic [5:0] TAG_HIGH = 6'b110110;
  localparam logic [5:0] TAG_LOW  = 6'b110111;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;      // bytes[0] goes out first
    logic [CNT_W-1:0]          count;      // 0 to 6
    logic                      held_valid; // high surrogate held after this unit
    logic [9:0]                held_bits;
  } enc_res_t;

endpackage

// ----- rtl/utf16le_to_utf8_replacing.sv -----
// ----------------------------------------------------------------------------
// UTF-16LE to UTF-8 transcoder with replacement
// Streams UTF-16 code units in and UTF-8 bytes out; unpaired surrogates
// become U+FFFD.
// ----------------------------------------------------------------------------
//  channel | tdata               | tlast           | words per item
//  --------+---------------------+-----------------+---------------
//  in_     | [15:0] code_unit    | end_of_payload  | 1
//  out_    | [7:0]  utf8_byte    | run_last        | 0 to 6
//
// A code unit yields as many bytes as it encodes to (1 to 6; a held high
// surrogate yields none), one byte per cycle while out_tready is high.
// The next unit is taken in the cycle the last byte of the current one
// leaves, so units follow back to back. Reset (synchronous, active low)
// drops the byte buffer and any held surrogate. Output stalls hold the
// buffer and the input waits.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_replacing (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // end_of_payload
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] utf8_byte
  output logic        out_tlast   // run_last
);
  import u16u8_pkg::*;

  enc_res_t                  enc;
  logic                      busy_r,      busy_nxt;
  logic [CNT_W-1:0]          cnt_r,       cnt_nxt;
  logic [CNT_W-1:0]          idx_r,       idx_nxt;
  logic [MAX_BYTES-1:0][7:0] bytes_r,     bytes_nxt;
  logic                      held_v_r,    held_v_nxt;
  logic [9:0]                held_bits_r, held_bits_nxt;
  logic                      in_fire;
  logic                      out_fire;
  logic                      at_last;

  u16u8_encode u_enc (
    .code_unit      (in_tdata),
    .end_of_payload (in_tlast),
    .held_valid     (held_v_r),
    .held_bits      (held_bits_r),
    .res            (enc)
  );

  // handshake
  assign at_last    = (idx_r == cnt_r - CNT_W'(1));
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = !busy_r || (out_fire && at_last);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = busy_r;
  assign out_tdata  = bytes_r[idx_r];
  assign out_tlast  = at_last;

  // buffer and held surrogate update
  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    bytes_nxt     = bytes_r;
    held_v_nxt    = held_v_r;
    held_bits_nxt = held_bits_r;
    if (in_fire) begin
      busy_nxt      = (enc.count != '0);
      cnt_nxt       = enc.count;
      idx_nxt       = '0;
      bytes_nxt     = enc.bytes;
      held_v_nxt    = enc.held_valid;
      held_bits_nxt = enc.held_bits;
    end else if (out_fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      held_v_r    <= 1'b0;
      held_bits_r <= '0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      held_v_r    <= held_v_nxt;
      held_bits_r <= held_bits_nxt;
    end
  end

  // byte buffer payload
  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

// ----- rtl/u16u8_encode.sv -----
// ----------------------------------------------------------------------------
// UTF-16 code unit encoder
// Turns one code unit plus the held high surrogate into up to six UTF-8
// bytes and the next held state.
// ----------------------------------------------------------------------------
module u16u8_encode (
  input  logic [15:0]         code_unit,
  input  logic                end_of_payload,
  input  logic                held_valid,
  input  logic [9:0]          held_bits,
  output u16u8_pkg::enc_res_t res
);
  import u16u8_pkg::*;

  logic                 is_high;
  logic                 is_low;
  logic                 pair;
  logic [20:0]          cp;
  logic [2:0][7:0]      bmp_b;
  logic [CNT_W-1:0]     bmp_n;
  logic [2:0][7:0]      main_b;
  logic [CNT_W-1:0]     main_n;
  logic [2:0][7:0]      repl_b;

  assign is_high = (code_unit[15:10] == TAG_HIGH);
  assign is_low  = (code_unit[15:10] == TAG_LOW);
  assign pair    = held_valid && is_low;
  assign cp      = 21'h10000 + {1'b0, held_bits, code_unit[9:0]};
  assign repl_b  = {REPL_B2, REPL_B1, REPL_B0};

  // plain BMP unit, one to three bytes
  always_comb begin
    bmp_b = '0;
    if (code_unit[15:7] == '0) begin
      bmp_b[0] = code_unit[7:0];
      bmp_n    = CNT_W'(1);
    end else if (code_unit[15:11] == '0) begin
      bmp_b[0] = {3'b110, code_unit[10:6]};
      bmp_b[1] = {2'b10, code_unit[5:0]};
      bmp_n    = CNT_W'(2);
    end else begin
      bmp_b[0] = {4'b1110, code_unit[15:12]};
      bmp_b[1] = {2'b10, code_unit[11:6]};
      bmp_b[2] = {2'b10, code_unit[5:0]};
      bmp_n    = CNT_W'(3);
    end
  end

  // bytes owed by this unit itself, apart from a pair
  always_comb begin
    if (is_low) begin
      main_b = repl_b;
      main_n = CNT_W'(REPL_LEN);
    end else if (is_high) begin
      main_b = end_of_payload ? repl_b : '0;
      main_n = end_of_payload ? CNT_W'(REPL_LEN) : '0;
    end else begin
      main_b = bmp_b;
      main_n = bmp_n;
    end
  end

  // assemble: pair, or replacement for a stale high surrogate then the unit
  always_comb begin
    res.bytes = '0;
    if (pair) begin
      res.bytes[0] = {5'b11110, cp[20:18]};
      res.bytes[1] = {2'b10, cp[17:12]};
      res.bytes[2] = {2'b10, cp[11:6]};
      res.bytes[3] = {2'b10, cp[5:0]};
      res.count    = CNT_W'(4);
    end else if (held_valid) begin
      res.bytes[2:0] = repl_b;
      res.bytes[5:3] = main_b;
      res.count      = main_n + CNT_W'(REPL_LEN);
    end else begin
      res.bytes[2:0] = main_b;
      res.count      = main_n;
    end
    // a high surrogate is held unless the payload ends here
    res.held_valid = is_high && !end_of_payload;
    res.held_bits  = res.held_valid ? code_unit[9:0] : '0;
  end

endmodule

// ----- rtl/u16u8_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder port checker
// Watches the top-level ports for framing and ordering slips.
// ----------------------------------------------------------------------------
`include "utf16le_to_utf8_replacing_assert.svh"

module u16u8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import u16u8_pkg::*;

  // bytes sent since the last run_last
  logic [CNT_W-1:0] run_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (out_tvalid && out_tready) begin
      run_cnt_r <= out_tlast ? '0 : run_cnt_r + CNT_W'(1);
    end
  end

  // an ASCII byte may follow a replacement for a stale high surrogate,
  // but it always closes the run
  `U16U8_ASSERT_RST(a_rst_idle, clk, !rst_n, !out_tvalid, "output valid after reset")
  `U16U8_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled byte changed")
  `U16U8_ASSERT_SAME(a_run_len, clk, rst_n, out_tvalid && !out_tlast, run_cnt_r < CNT_W'(MAX_BYTES - 1), "run longer than six bytes")
  `U16U8_ASSERT_SAME(a_ascii, clk, rst_n, out_tvalid && !out_tdata[7], out_tlast, "ASCII byte not last in its run")
  `U16U8_ASSERT_SAME(a_lead4, clk, rst_n, out_tvalid && out_tdata[7:3] == 5'b11110, !out_tlast, "four-byte lead ends a run")

endmodule

bind utf16le_to_utf8_replacing u16u8_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- verif/tb_utf16le_to_utf8_replacing.sv -----
// ----------------------------------------------------------------------------
// Testbench for the UTF-16LE to UTF-8 transcoder with replacement
// Feeds code units through a clocked driver with random gaps, predicts the
// UTF-8 byte stream (surrogate pairing and U+FFFD replacement included) and
// checks every output word in order against that prediction.
// ----------------------------------------------------------------------------
module tb_utf16le_to_utf8_replacing;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  localparam int STALL_LIMIT = 4000;  // cycles with no handshake on either side
  localparam int RX_HOLD_AT  = 400;   // output word count where the long hold starts
  localparam int RX_HOLD_LEN = 300;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [15:0] unit;
    logic        eop;
    int          gap;
    logic        drain;  // marker: sender waits until all bytes are out
  } unit_item_t;

  typedef struct {
    logic [7:0] octet;
    logic       last;
  } utf8_word_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  utf16le_to_utf8_replacing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] code_unit
    .in_tlast  (in_tlast),   // end_of_payload
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] utf8_byte
    .out_tlast (out_tlast)   // run_last
  );

  // stimulus and expected byte stream
  unit_item_t stim_q[$];
  utf8_word_t pending_utf8[$];

  // predictor state
  logic [9:0] pair_bits = '0;
  logic       pair_open = 1'b0;
  logic [7:0] unit_bytes[MAX_BYTES];
  int         unit_len;

  // bookkeeping
  int  units_queued  = 0;
  int  units_sent    = 0;
  int  bytes_seen    = 0;
  int  pairs_seen    = 0;
  int  fffd_seen     = 0;
  int  mismatches    = 0;
  int  idle_cycles   = 0;
  bit  timed_out     = 1'b0;
  bit  sender_burst  = 1'b0;

  // driver state
  unit_item_t cur;
  bit         have_cur  = 1'b0;
  int         gap_left  = 0;

  // receiver state
  int rx_wait   = 0;
  bit rx_held   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void add_octet(logic [7:0] b);
    unit_bytes[unit_len] = b;
    unit_len++;
  endfunction

  function automatic void add_fffd();
    add_octet(REPL_B0);
    add_octet(REPL_B1);
    add_octet(REPL_B2);
    fffd_seen++;
  endfunction

  // works out the bytes one accepted code unit produces, queues them
  function automatic void transcode_unit(logic [15:0] cu, logic eop);
    logic        is_hi;
    logic        is_lo;
    logic [20:0] cp;
    utf8_word_t  w;
    is_hi    = (cu[15:10] == TAG_HIGH);
    is_lo    = (cu[15:10] == TAG_LOW);
    unit_len = 0;
    if (pair_open && is_lo) begin
      cp = 21'h10000 + {1'b0, pair_bits, cu[9:0]};
      add_octet({5'b11110, cp[20:18]});
      add_octet({2'b10, cp[17:12]});
      add_octet({2'b10, cp[11:6]});
      add_octet({2'b10, cp[5:0]});
      pair_open = 1'b0;
      pair_bits = '0;
      pairs_seen++;
    end else begin
      // held high surrogate without its low half
      if (pair_open) begin
        add_fffd();
        pair_open = 1'b0;
        pair_bits = '0;
      end
      if (is_lo) begin
        add_fffd();
      end else if (is_hi) begin
        if (eop) begin
          add_fffd();
        end else begin
          pair_bits = cu[9:0];
          pair_open = 1'b1;
        end
      end else if (cu < 16'h0080) begin
        add_octet(cu[7:0]);
      end else if (cu < 16'h0800) begin
        add_octet({3'b110, cu[10:6]});
        add_octet({2'b10, cu[5:0]});
      end else begin
        add_octet({4'b1110, cu[15:12]});
        add_octet({2'b10, cu[11:6]});
        add_octet({2'b10, cu[5:0]});
      end
    end
    // a payload never carries a surrogate into the next one
    if (eop) begin
      pair_open = 1'b0;
      pair_bits = '0;
    end
    for (int i = 0; i < unit_len; i++) begin
      w.octet = unit_bytes[i];
      w.last  = (i == unit_len - 1);
      pending_utf8.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_unit(logic [15:0] u, logic e);
    unit_item_t it;
    it.unit  = u;
    it.eop   = e;
    it.gap   = sender_burst ? 0 : $urandom_range(0, 16);
    it.drain = 1'b0;
    stim_q.push_back(it);
    units_queued++;
  endfunction

  function automatic void add_drain();
    unit_item_t it;
    it.unit  = '0;
    it.eop   = 1'b0;
    it.gap   = 0;
    it.drain = 1'b1;
    stim_q.push_back(it);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one code unit per word, random gap before each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        transcode_unit(in_tdata, in_tlast);
        units_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        // drain marker: hold off until every expected byte has arrived
        if (!have_cur && stim_q.size() > 0 && stim_q[0].drain &&
            pending_utf8.size() == 0)
          void'(stim_q.pop_front());
        if (!have_cur && stim_q.size() > 0 && !stim_q[0].drain) begin
          cur      = stim_q.pop_front();
          gap_left = cur.gap;
          have_cur = 1'b1;
        end
        if (have_cur) begin
          if (gap_left == 0) begin
            busy      = 1'b1;
            in_tdata  <= cur.unit;
            in_tlast  <= cur.eop;
            have_cur  = 1'b0;
          end else begin
            gap_left--;
          end
        end
      end
      in_tvalid <= busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random ready stalls, one long hold, in-order byte check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    utf8_word_t w;
    bit         rx_burst;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      rx_burst = ((bytes_seen / 60) % 3 == 2);
      if (out_tvalid && out_tready) begin
        if (pending_utf8.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected word: data %02h last %0b",
                     $realtime, out_tdata, out_tlast);
          mismatches++;
        end else begin
          w = pending_utf8.pop_front();
          if (out_tdata !== w.octet || out_tlast !== w.last) begin
            if (mismatches < 10)
              $display("[%0t] byte %0d: expected %02h last %0b, got %02h last %0b",
                       $realtime, bytes_seen, w.octet, w.last, out_tdata, out_tlast);
            mismatches++;
          end
        end
        bytes_seen++;
        if (bytes_seen == RX_HOLD_AT && !rx_held) begin
          rx_wait = RX_HOLD_LEN;
          rx_held = 1'b1;
        end else begin
          rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no handshake on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT)
        timed_out <= 1'b1;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int         sel;
    int         next_switch;
    int         next_drain;
    logic       e;
    logic [9:0] r10;
    logic [15:0] u;

    // directed: range edges of each encoding length
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hD7FF, 1'b0);
    add_unit(16'hE000, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    // lowest and highest surrogate pairs
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b1);
    // lone low surrogates
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDFFF, 1'b0);
    // held high followed by ASCII, ending the payload
    add_unit(16'hD801, 1'b0);
    add_unit(16'h0041, 1'b1);
    // high, high, low: replacement then a pair
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDC01, 1'b0);
    // held high then a high at end of payload: six bytes
    add_unit(16'hD800, 1'b0);
    add_unit(16'hD900, 1'b1);
    // high surrogate alone at end of payload
    add_unit(16'hDBFF, 1'b1);
    // held high followed by a three-byte unit: six bytes
    add_unit(16'hDA00, 1'b0);
    add_unit(16'hFFFF, 1'b0);
    // pair ending the payload
    add_unit(16'hD834, 1'b0);
    add_unit(16'hDD1E, 1'b1);
    add_drain();

    // random: mostly well-formed text, some broken surrogates and noise
    next_switch = units_queued;
    next_drain  = units_queued + 110;
    while (units_queued < 320) begin
      if (units_queued >= next_switch) begin
        sender_burst = ($urandom_range(0, 2) == 0);
        next_switch  = units_queued + 40;
      end
      if (units_queued >= next_drain) begin
        add_drain();
        next_drain = units_queued + 110;
      end
      sel = $urandom_range(0, 99);
      e   = ($urandom_range(0, 7) == 0);
      r10 = 10'($urandom);
      if (sel < 20) begin
        add_unit(16'($urandom_range(0, 16'h007F)), e);
      end else if (sel < 35) begin
        add_unit(16'($urandom_range(16'h0080, 16'h07FF)), e);
      end else if (sel < 55) begin
        u = 16'($urandom_range(16'h0800, 16'hFFFF));
        if (u[15:11] == 5'b11011)
          u = u ^ 16'h4000;
        add_unit(u, e);
      end else if (sel < 80) begin
        add_unit({TAG_HIGH, r10}, 1'b0);
        add_unit({TAG_LOW, 10'($urandom)}, e);
      end else if (sel < 88) begin
        add_unit({TAG_HIGH, r10}, e);
      end else if (sel < 95) begin
        add_unit({TAG_LOW, r10}, e);
      end else begin
        add_unit(16'($urandom), e);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!(stim_q.size() == 0 && !have_cur && !in_tvalid &&
             pending_utf8.size() == 0) && !timed_out)
      @(negedge clk);

    if (timed_out) begin
      $display("timeout: %0d bytes still expected, %0d units unsent",
               pending_utf8.size(), stim_q.size());
      $display("FAILED: results differ");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      $display("Sent %0d code units: %0d surrogate pairs, %0d replacements",
               units_sent, pairs_seen, fffd_seen);
      $display("Checked %0d UTF-8 bytes, %0d mismatches, %0d left over",
               bytes_seen, mismatches, pending_utf8.size());
      if (mismatches == 0 && pending_utf8.size() == 0)
        $display("PASSED: all results match");
      else
        $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
